>>> rtl/rgb_to_hsl_defines.svh
`ifndef RGB_TO_HSL_DEFINES_SVH
`define RGB_TO_HSL_DEFINES_SVH

// check a property on every edge outside reset
`define RTH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every edge, reset included
`define RTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/rgb2hsl_pkg.sv
`default_nettype none

package rgb2hsl_pkg;

   localparam int CHAN_W      = 8;
   localparam int HUE_W       = 12;
   localparam int SAT_W       = 10;
   localparam int LIGHT_W     = 10;

   localparam int HUE_NUM_W   = 21;
   localparam int HUE_DEN_W   = 9;
   localparam int SAT_NUM_W   = 19;
   localparam int SAT_DEN_W   = 9;
   localparam int LIGHT_NUM_W = 20;
   localparam int QUO_W       = 12;

   // ceil(2**30 / 1020): exact floor division for light_num below 2**20
   localparam int LIGHT_RCP_W = 21;
   localparam int LIGHT_SHIFT = 30;
   localparam logic [LIGHT_RCP_W-1:0] LIGHT_RCP = LIGHT_RCP_W'(1052689);

   typedef struct packed {
      logic [HUE_NUM_W-1:0]   hue_num;
      logic [HUE_DEN_W-1:0]   hue_den;
      logic [SAT_NUM_W-1:0]   sat_num;
      logic [SAT_DEN_W-1:0]   sat_den;
      logic [LIGHT_NUM_W-1:0] light_num;
   } prep_type;

endpackage

`default_nettype wire

>>> rtl/rgb_to_hsl.sv
// Throughput: one word per clock; a prep stage feeds two 12-stage
// restoring dividers for hue and saturation that run in lockstep, one
// quotient bit per stage, and a reciprocal multiply for lightness, delayed to match.
// A stalled response holds the whole pipeline in place.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none

`include "rgb_to_hsl_defines.svh"

module rgb_to_hsl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_blue,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [rgb2hsl_pkg::HUE_W-1:0]       rsp_hue_tenths,
   output logic      [rgb2hsl_pkg::SAT_W-1:0]       rsp_saturation_tenths,
   output logic      [rgb2hsl_pkg::LIGHT_W-1:0]     rsp_lightness_tenths
);

   localparam int STAGES       = 1 + rgb2hsl_pkg::QUO_W;
   localparam int LIGHT_PROD_W = rgb2hsl_pkg::LIGHT_NUM_W + rgb2hsl_pkg::LIGHT_RCP_W;

   logic                             advance;
   logic [STAGES-1:0]                valid_ff;
   logic [STAGES-1:0]                valid_in;
   rgb2hsl_pkg::prep_type            prep_ff;
   logic [rgb2hsl_pkg::QUO_W-1:0]    hue_quo;
   logic [rgb2hsl_pkg::QUO_W-1:0]    sat_quo;
   logic [LIGHT_PROD_W-1:0]          light_prod;
   logic [rgb2hsl_pkg::LIGHT_W-1:0]  light_ff [rgb2hsl_pkg::QUO_W];
   logic                             rsp_gray;

   assign advance   = !valid_ff[STAGES-1] || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rgb2hsl_prep u_prep (
      .clock   (clock),
      .advance (advance),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .prep_ff (prep_ff)
   );

   rgb2hsl_div #(
      .NUM_W (rgb2hsl_pkg::HUE_NUM_W),
      .DEN_W (rgb2hsl_pkg::HUE_DEN_W),
      .QUO_W (rgb2hsl_pkg::QUO_W)
   ) u_hue_div (
      .clock   (clock),
      .advance (advance),
      .num     (prep_ff.hue_num),
      .den     (prep_ff.hue_den),
      .quo     (hue_quo)
   );

   rgb2hsl_div #(
      .NUM_W (rgb2hsl_pkg::SAT_NUM_W),
      .DEN_W (rgb2hsl_pkg::SAT_DEN_W),
      .QUO_W (rgb2hsl_pkg::QUO_W)
   ) u_sat_div (
      .clock   (clock),
      .advance (advance),
      .num     (prep_ff.sat_num),
      .den     (prep_ff.sat_den),
      .quo     (sat_quo)
   );

   assign light_prod = LIGHT_PROD_W'(prep_ff.light_num)
                     * LIGHT_PROD_W'(rgb2hsl_pkg::LIGHT_RCP);

   // hold lightness in step with the dividers
   always_ff @(posedge clock) begin
      if (advance) begin
         light_ff[0] <= light_prod[rgb2hsl_pkg::LIGHT_SHIFT +: rgb2hsl_pkg::LIGHT_W];
         for (int k = 1; k < rgb2hsl_pkg::QUO_W; k++) begin
            light_ff[k] <= light_ff[k-1];
         end
      end
   end

   assign rsp_valid             = valid_ff[STAGES-1];
   assign rsp_hue_tenths        = hue_quo[rgb2hsl_pkg::HUE_W-1:0];
   assign rsp_saturation_tenths = sat_quo[rgb2hsl_pkg::SAT_W-1:0];
   assign rsp_lightness_tenths  = light_ff[rgb2hsl_pkg::QUO_W-1];
   assign rsp_gray              = (rsp_saturation_tenths == '0);

   `RTH_ASSERT(a_hue_range, clock, reset, rsp_valid |-> rsp_hue_tenths <= 12'd3599, "hue range")
   `RTH_ASSERT(a_sat_range, clock, reset, rsp_valid |-> rsp_saturation_tenths <= 10'd1000, "sat range")
   `RTH_ASSERT(a_light_range, clock, reset, rsp_valid |-> rsp_lightness_tenths <= 10'd1000, "light range")
   `RTH_ASSERT(a_gray_hue, clock, reset, rsp_valid && rsp_gray |-> rsp_hue_tenths == '0, "gray hue")
   `RTH_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> !rsp_valid, "valid after reset")

endmodule

`default_nettype wire

>>> rtl/rgb2hsl_prep.sv
`default_nettype none

module rgb2hsl_prep (
   input  wire logic                               clock,
   input  wire logic                               advance,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]     red,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]     green,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]     blue,
   output rgb2hsl_pkg::prep_type                   prep_ff
);

   localparam logic [11:0] BASE_RED_POS = 12'd0;
   localparam logic [11:0] BASE_RED_NEG = 12'd3600;
   localparam logic [11:0] BASE_GREEN   = 12'd1200;
   localparam logic [11:0] BASE_BLUE    = 12'd2400;

   rgb2hsl_pkg::prep_type prep_in;

   logic [7:0]         mx;
   logic [7:0]         mn;
   logic [7:0]         d;
   logic [8:0]         s;
   logic [7:0]         den;
   logic [11:0]        base;
   logic signed [8:0]  x;
   logic [19:0]        base_d;
   logic signed [21:0] hue_sum;
   logic [19:0]        hue_num;

   always_comb begin
      mx = (red > green) ? red : green;
      if (blue > mx) begin
         mx = blue;
      end
      mn = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      d = mx - mn;
      s = {1'b0, mx} + {1'b0, mn};
      den = (s <= 9'd255) ? s[7:0] : 8'(9'd510 - s);

      if (mx == red) begin
         x    = $signed({1'b0, green}) - $signed({1'b0, blue});
         base = (green >= blue) ? BASE_RED_POS : BASE_RED_NEG;
      end else if (mx == green) begin
         x    = $signed({1'b0, blue}) - $signed({1'b0, red});
         base = BASE_GREEN;
      end else begin
         x    = $signed({1'b0, red}) - $signed({1'b0, green});
         base = BASE_BLUE;
      end
      base_d  = 20'(base) * 20'(d);
      hue_sum = $signed({2'b00, base_d}) + 22'(x) * 22'sd600;
      hue_num = hue_sum[19:0];

      prep_in.light_num = 20'(s) * 20'd2000 + 20'd510;
      if (d == 8'd0) begin
         prep_in.hue_num = '0;
         prep_in.hue_den = 9'd2;
         prep_in.sat_num = '0;
         prep_in.sat_den = 9'd2;
      end else begin
         prep_in.hue_num = {hue_num, 1'b0} + 21'(d);
         prep_in.hue_den = {d, 1'b0};
         prep_in.sat_num = 19'(d) * 19'd2000 + 19'(den);
         prep_in.sat_den = {den, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rgb2hsl_div.sv
`default_nettype none

module rgb2hsl_div #(
   parameter int NUM_W = rgb2hsl_pkg::HUE_NUM_W,
   parameter int DEN_W = rgb2hsl_pkg::HUE_DEN_W,
   parameter int QUO_W = rgb2hsl_pkg::QUO_W
) (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);

   localparam int CMP_W = NUM_W + DEN_W;

   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;

      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [CMP_W-1:0] shifted;
      logic             take;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         shifted     = CMP_W'(den_prev) << BIT;
         take        = CMP_W'(rem_prev) >= shifted;
         rem_in      = take ? NUM_W'(CMP_W'(rem_prev) - shifted) : rem_prev;
         quo_in      = quo_prev;
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

>>> tb/rgb_to_hsl_checker.sv
`timescale 1ns / 100ps

module rgb_to_hsl_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]      req_blue,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [rgb2hsl_pkg::HUE_W-1:0]       rsp_hue_tenths,
   input  wire logic [rgb2hsl_pkg::SAT_W-1:0]       rsp_saturation_tenths,
   input  wire logic [rgb2hsl_pkg::LIGHT_W-1:0]     rsp_lightness_tenths,
   output int unsigned                              error_count,
   output int unsigned                              words_pending
);

   localparam int CW = rgb2hsl_pkg::CHAN_W;
   localparam int HW = rgb2hsl_pkg::HUE_W;
   localparam int SW = rgb2hsl_pkg::SAT_W;
   localparam int LW = rgb2hsl_pkg::LIGHT_W;

   typedef struct packed {
      logic [HW-1:0] hue;
      logic [SW-1:0] sat;
      logic [LW-1:0] light;
   } hsl_word_type;

   hsl_word_type hsl_expected [$];
   int unsigned  fail_total = 0;

   initial begin
      error_count   = 0;
      words_pending = 0;
   end

   function automatic int unsigned round_half_up(input int unsigned num,
                                                 input int unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_word_type hsl_of_pixel(input logic [CW-1:0] r,
                                                 input logic [CW-1:0] g,
                                                 input logic [CW-1:0] b);
      int unsigned  rr, gg, bb, mx, mn, d, s, den, num;
      hsl_word_type w;
      rr = r;
      gg = g;
      bb = b;
      mx = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      mn = rr;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      d = mx - mn;
      s = mx + mn;
      w.light = LW'(round_half_up(1000 * s, 510));
      w.hue   = '0;
      w.sat   = '0;
      if (d != 0) begin
         den   = (s <= 255) ? s : 510 - s;
         w.sat = SW'(round_half_up(1000 * d, den));
         // red wins ties over green, green over blue
         if (mx == rr) begin
            num = (gg >= bb) ? 600 * (gg - bb) : 3600 * d - 600 * (bb - gg);
         end else if (mx == gg) begin
            num = 1200 * d + 600 * bb - 600 * rr;
         end else begin
            num = 2400 * d + 600 * rr - 600 * gg;
         end
         w.hue = HW'(round_half_up(num, d));
      end
      return w;
   endfunction

   always @(posedge clock) begin
      hsl_word_type want, got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            hsl_expected.push_back(hsl_of_pixel(req_red, req_green, req_blue));
         end
         if (rsp_valid && !rsp_stall) begin
            got.hue   = rsp_hue_tenths;
            got.sat   = rsp_saturation_tenths;
            got.light = rsp_lightness_tenths;
            if (hsl_expected.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("%0t: unexpected word: hue %0d sat %0d light %0d",
                           $time, got.hue, got.sat, got.light);
               end
            end else begin
               want = hsl_expected.pop_front();
               if (got.hue !== want.hue || got.sat !== want.sat ||
                   got.light !== want.light) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: mismatch (exp/act): hue %0d/%0d sat %0d/%0d",
                              $time, want.hue, got.hue, want.sat, got.sat);
                     $display("%0t:   light %0d/%0d", $time, want.light, got.light);
                  end
               end
            end
         end
      end
      error_count   <= fail_total;
      words_pending <= hsl_expected.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int          CW          = rgb2hsl_pkg::CHAN_W;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned N_RANDOM    = 1600;
   localparam int          N_DIRECTED  = 22;

   localparam logic [23:0] DIRECTED_PX [N_DIRECTED] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F,
      24'hFF0001, 24'h010000, 24'h000001, 24'h800000, 24'hFF0080,
      24'hFF0180, 24'hFEFFFF, 24'h807F7F, 24'hFFFFFE, 24'h000101,
      24'hAB12CD, 24'h7F8080
   };

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [CW-1:0]                 req_red   = '0;
   logic [CW-1:0]                 req_green = '0;
   logic [CW-1:0]                 req_blue  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [rgb2hsl_pkg::HUE_W-1:0]   rsp_hue_tenths;
   logic [rgb2hsl_pkg::SAT_W-1:0]   rsp_saturation_tenths;
   logic [rgb2hsl_pkg::LIGHT_W-1:0] rsp_lightness_tenths;

   int unsigned error_count;
   int unsigned words_pending;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   always #5 clock = ~clock;

   rgb_to_hsl dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hue_tenths        (rsp_hue_tenths),
      .rsp_saturation_tenths (rsp_saturation_tenths),
      .rsp_lightness_tenths  (rsp_lightness_tenths)
   );

   rgb_to_hsl_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hue_tenths        (rsp_hue_tenths),
      .rsp_saturation_tenths (rsp_saturation_tenths),
      .rsp_lightness_tenths  (rsp_lightness_tenths),
      .error_count           (error_count),
      .words_pending         (words_pending)
   );

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[rgb_to_hsl] ERROR");
      $finish;
   end

   // offer one pixel word, with a random gap between bursts
   task automatic offer_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                              input logic [CW-1:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: stall modes of random length, plus two long hold-offs
   initial begin
      int unsigned cyc, mode, mode_left;
      cyc       = 0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if ((cyc >= 400 && cyc < 700) || (cyc >= 2500 && cyc < 2800)) begin
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      int unsigned   i, pick;
      logic [CW-1:0] r, g, b, base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < N_DIRECTED; i++) begin
         offer_pixel(DIRECTED_PX[i][23:16], DIRECTED_PX[i][15:8], DIRECTED_PX[i][7:0]);
      end
      for (i = 0; i < N_RANDOM; i++) begin
         pick = $urandom_range(0, 9);
         r    = CW'($urandom);
         g    = CW'($urandom);
         b    = CW'($urandom);
         base = CW'($urandom);
         case (pick)
            5: begin
               g = r;
               b = r;
            end
            6: begin
               case ($urandom_range(0, 2))
                  0: g = r;
                  1: b = g;
                  default: b = r;
               endcase
            end
            7: begin
               r = ($urandom_range(0, 2) == 0) ? 8'h00 : ($urandom_range(0, 1) ? 8'hFF : r);
               g = ($urandom_range(0, 2) == 0) ? 8'h00 : ($urandom_range(0, 1) ? 8'hFF : g);
               b = ($urandom_range(0, 2) == 0) ? 8'h00 : ($urandom_range(0, 1) ? 8'hFF : b);
            end
            8: begin
               r = (base > 8'd252) ? base - 8'd3 : base;
               g = r + CW'($urandom_range(0, 2));
               b = r + CW'($urandom_range(0, 2));
            end
            9: begin
               case ($urandom_range(0, 2))
                  0: r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  1: g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  default: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               endcase
            end
            default: ;
         endcase
         offer_pixel(r, g, b);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && words_pending == 0) begin
         $display("[rgb_to_hsl] OK");
      end else begin
         $display("[rgb_to_hsl] ERROR");
      end
      $finish;
   end

endmodule
